[hdl/imas_pkg.sv]
// Package with the widths, heap entry type and controller/datapath signal groups.
`timescale 1ns / 1ps
package imas_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = AW + 1;
  localparam int TW = 48;
  localparam int MW = 32;
  localparam int DW = 32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [TW-1:0] finish;
    logic [MW-1:0] mem;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop_root;
    logic pop_last;
    logic pop_cur;
    logic sd_l;
    logic sd_r;
    logic sd_cmp;
    logic push;
    logic su_chk;
    logic su_cmp;
    logic set_over;
    logic set_full;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_ok;
    logic need_gt_free;
    logic heap_empty;
    logic heap_full;
    logic l_in;
    logic sd_more;
    logic su_root;
    logic su_stop;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

[hdl/imas_in_if.sv]
// Input channel interface carrying one job item.
`timescale 1ns / 1ps
interface imas_in_if;
  logic                    valid;
  logic                    ready;
  logic [imas_pkg::DW-1:0] duration;
  logic [imas_pkg::MW-1:0] mem_need;
  logic                    last;

  modport source (output valid, duration, mem_need, last, input ready);
  modport sink (input valid, duration, mem_need, last, output ready);
endinterface

[hdl/imas_out_if.sv]
// Result channel interface carrying the makespan and status of a run.
`timescale 1ns / 1ps
interface imas_out_if;
  logic                    valid;
  logic                    ready;
  logic [imas_pkg::TW-1:0] makespan;
  logic [1:0]              status;

  modport source (output valid, makespan, status, input ready);
  modport sink (input valid, makespan, status, output ready);
endinterface

[hdl/imas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/imas_ctrl.sv]
// Controller state machine sequencing admission, heap pops and heap pushes.
`timescale 1ns / 1ps
module imas_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  imas_pkg::stat_t stat,
  output imas_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DEC      = 11'b000_0000_0010,
    S_POP_ROOT = 11'b000_0000_0100,
    S_POP_LAST = 11'b000_0000_1000,
    S_POP_CUR  = 11'b000_0001_0000,
    S_SD_L     = 11'b000_0010_0000,
    S_SD_R     = 11'b000_0100_0000,
    S_SD_CMP   = 11'b000_1000_0000,
    S_SU_CHK   = 11'b001_0000_0000,
    S_SU_CMP   = 11'b010_0000_0000,
    S_END      = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (!stat.run_ok) begin
          state_nxt = S_END;
        end else if (stat.need_gt_free && !stat.heap_empty) begin
          cmd.pop_root = 1'b1;
          state_nxt    = S_POP_ROOT;
        end else if (stat.need_gt_free) begin
          cmd.set_over = 1'b1;
          state_nxt    = S_END;
        end else if (stat.heap_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_END;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_SU_CHK;
        end
      end
      S_POP_ROOT: begin
        cmd.pop_last = 1'b1;
        state_nxt    = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.pop_cur = 1'b1;
        state_nxt   = S_SD_L;
      end
      S_POP_CUR: begin
        state_nxt = S_SD_L;
      end
      S_SD_L: begin
        cmd.sd_l  = 1'b1;
        state_nxt = stat.l_in ? S_SD_R : S_DEC;
      end
      S_SD_R: begin
        cmd.sd_r  = 1'b1;
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.sd_cmp = 1'b1;
        state_nxt  = stat.sd_more ? S_SD_L : S_DEC;
      end
      S_SU_CHK: begin
        cmd.su_chk = 1'b1;
        state_nxt  = stat.su_root ? S_END : S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd.su_cmp = 1'b1;
        state_nxt  = stat.su_stop ? S_END : S_SU_CHK;
      end
      S_END: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/imas_dp.sv]
// Datapath: run registers, job registers, heap memory and result register.
`timescale 1ns / 1ps
module imas_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [imas_pkg::MW-1:0] cfg_wdata,
  input  logic [imas_pkg::DW-1:0] in_duration,
  input  logic [imas_pkg::MW-1:0] in_mem_need,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [imas_pkg::TW-1:0] out_makespan,
  output logic [1:0]              out_status,
  input  imas_pkg::cmd_t          cmd,
  output imas_pkg::stat_t         stat
);

  localparam int AW = imas_pkg::AW;
  localparam int CW = imas_pkg::CW;
  localparam int TW = imas_pkg::TW;
  localparam int MW = imas_pkg::MW;

  logic [MW-1:0]    total_r;
  logic             open_r, open_nxt;
  logic [MW-1:0]    free_r, free_nxt;
  logic [TW-1:0]    time_r, time_nxt;
  logic [TW-1:0]    latest_r, latest_nxt;
  logic [1:0]       rstat_r, rstat_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [imas_pkg::DW-1:0] dur_r;
  logic [MW-1:0]    need_r;
  logic             last_r;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    bidx_r;
  logic             rv_r;
  imas_pkg::entry_t cur_r, cur_nxt;
  imas_pkg::entry_t best_r;
  logic             out_valid_r, out_valid_nxt;
  logic [TW-1:0]    out_makespan_r;
  logic [1:0]       out_status_r;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  imas_pkg::entry_t ram_wdata, ram_rdata;

  logic [CW:0]      lidx, ridx;
  logic [AW-1:0]    pidx;
  logic [CW-1:0]    cnt_dec;
  logic [TW:0]      fsum;
  logic [TW-1:0]    finish_val;
  logic             right_wins;
  imas_pkg::entry_t pick;
  logic [AW-1:0]    pick_idx;

  imas_ram #(.WIDTH(imas_pkg::EW), .DEPTH(imas_pkg::HEAP_DEPTH)) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Heap index arithmetic.
  assign lidx     = {1'b0, idx_r, 1'b1};
  assign ridx     = lidx + (CW+1)'(1);
  assign pidx     = AW'((idx_r - AW'(1)) >> 1);
  assign cnt_dec  = count_r - CW'(1);
  assign fsum     = {1'b0, time_r} + (TW+1)'(dur_r);
  assign finish_val = fsum[TW] ? {TW{1'b1}} : fsum[TW-1:0];

  // Smaller of the two children during a sift down.
  assign right_wins = rv_r && (ram_rdata.finish < best_r.finish);
  assign pick       = right_wins ? ram_rdata : best_r;
  assign pick_idx   = right_wins ? AW'(bidx_r + AW'(1)) : bidx_r;

  // Status to the controller.
  always_comb begin
    stat.run_ok       = (rstat_r == imas_pkg::ST_OK);
    stat.need_gt_free = (need_r > free_r);
    stat.heap_empty   = (count_r == '0);
    stat.heap_full    = (count_r >= CW'(imas_pkg::HEAP_DEPTH));
    stat.l_in         = (lidx < {1'b0, count_r});
    stat.sd_more      = (pick.finish < cur_r.finish);
    stat.su_root      = (idx_r == '0);
    stat.su_stop      = (ram_rdata.finish <= cur_r.finish);
    stat.last         = last_r;
    stat.out_busy     = out_valid_r && !out_ready;
  end

  // Memory accesses and next values of the run registers.
  always_comb begin
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = cur_r;
    ram_raddr     = '0;
    open_nxt      = open_r;
    free_nxt      = free_r;
    time_nxt      = time_r;
    latest_nxt    = latest_r;
    rstat_nxt     = rstat_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load && !open_r) begin
      free_nxt = total_r;
      open_nxt = 1'b1;
    end
    if (cmd.pop_root) begin
      ram_re = 1'b1;
    end
    if (cmd.pop_last) begin
      time_nxt  = ram_rdata.finish;
      free_nxt  = free_r + ram_rdata.mem;
      count_nxt = cnt_dec;
      ram_re    = 1'b1;
      ram_raddr = cnt_dec[AW-1:0];
    end
    if (cmd.pop_cur) begin
      cur_nxt = ram_rdata;
      idx_nxt = '0;
    end
    if (cmd.sd_l) begin
      if (stat.l_in) begin
        ram_re    = 1'b1;
        ram_raddr = lidx[AW-1:0];
      end else begin
        ram_we = 1'b1;
      end
    end
    if (cmd.sd_r) begin
      ram_re    = 1'b1;
      ram_raddr = ridx[AW-1:0];
    end
    if (cmd.sd_cmp) begin
      ram_we = 1'b1;
      if (stat.sd_more) begin
        ram_wdata = pick;
        idx_nxt   = pick_idx;
      end
    end
    if (cmd.push) begin
      cur_nxt.finish = finish_val;
      cur_nxt.mem    = need_r;
      idx_nxt        = count_r[AW-1:0];
      count_nxt      = count_r + CW'(1);
      free_nxt       = free_r - need_r;
      if (finish_val > latest_r) begin
        latest_nxt = finish_val;
      end
    end
    if (cmd.su_chk) begin
      if (stat.su_root) begin
        ram_we = 1'b1;
      end else begin
        ram_re    = 1'b1;
        ram_raddr = pidx;
      end
    end
    if (cmd.su_cmp) begin
      ram_we = 1'b1;
      if (!stat.su_stop) begin
        ram_wdata = ram_rdata;
        idx_nxt   = pidx;
      end
    end
    if (cmd.set_over) begin
      rstat_nxt = imas_pkg::ST_OVERSIZE;
    end
    if (cmd.set_full) begin
      rstat_nxt = imas_pkg::ST_FULL;
    end
    // The result goes out and the run state returns to its reset value.
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      open_nxt      = 1'b0;
      free_nxt      = '0;
      time_nxt      = '0;
      latest_nxt    = '0;
      rstat_nxt     = imas_pkg::ST_OK;
      count_nxt     = '0;
    end
  end

  // Control registers of the run and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      open_r      <= 1'b0;
      free_r      <= '0;
      time_r      <= '0;
      latest_r    <= '0;
      rstat_r     <= imas_pkg::ST_OK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      open_r      <= open_nxt;
      time_r      <= time_nxt;
      latest_r    <= latest_nxt;
      rstat_r     <= rstat_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the job, the sift and the result.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    if (cmd.load) begin
      dur_r  <= in_duration;
      need_r <= in_mem_need;
      last_r <= in_last;
    end
    if (cmd.sd_r) begin
      best_r <= ram_rdata;
      bidx_r <= lidx[AW-1:0];
      rv_r   <= (ridx < {1'b0, count_r});
    end
    if (cmd.finish) begin
      out_makespan_r <= latest_r;
      out_status_r   <= rstat_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_makespan = out_makespan_r;
  assign out_status   = out_status_r;

endmodule

[hdl/in_order_memory_admission_scheduler_core.sv]
// Top level of the in-order memory admission scheduler.
`timescale 1ns / 1ps
// Jobs arrive in order as items of duration and memory need; each one is
// admitted once enough memory is free, completing running jobs earliest
// finish first, and the item marked last produces one result with the run's
// makespan and status, after which the block starts a fresh run using
// total_memory as written on cfg_wdata. One item is handled at a time, and
// every heap step of a sift down or sift up goes through the single read
// port of the heap memory. No clearing pass after reset is needed.
module in_order_memory_admission_scheduler_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [imas_pkg::MW-1:0] cfg_wdata,
  imas_in_if.sink                 in_ch,
  imas_out_if.source              out_ch
);

  imas_pkg::cmd_t  cmd;
  imas_pkg::stat_t stat;

  // Sequencer.
  imas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Heap and run state.
  imas_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_duration  (in_ch.duration),
    .in_mem_need  (in_ch.mem_need),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_makespan (out_ch.makespan),
    .out_status   (out_ch.status),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[hdl/imas_checker.sv]
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
module imas_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [imas_pkg::TW-1:0] out_makespan,
  input logic [1:0]              out_status
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_makespan) && $stable(out_status))
    else $error("result changed while stalled");

  // Only the three defined status codes appear.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // One item at a time: no acceptance right after an acceptance.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind in_order_memory_admission_scheduler_core imas_checker u_imas_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_makespan (out_ch.makespan),
  .out_status   (out_ch.status)
);
